>>> hw/rtl/hsa_pkg.sv
// Shared types, sizes and codes for the heap sort unit.
// No dependencies; hsa_sorter and heap_sort_ascending_unit import this package.
`default_nettype none

package hsa_pkg;

    localparam int DEPTH  = 1024;
    localparam int WIDTH  = 32;
    localparam int VAL_W  = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef logic signed [WIDTH-1:0] elem_t;
    typedef logic [ADDR_W-1:0]       addr_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [1:0]              status_t;

    localparam logic    CMD_PUSH     = 1'b0;
    localparam logic    CMD_POP      = 1'b1;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_EMPTY = 2'd1;
    localparam status_t STATUS_FULL  = 2'd2;

    // one access slot of the element RAM
    typedef struct packed {
        logic  rd_en;
        addr_t rd_addr;
        logic  wr_en;
        addr_t wr_addr;
        elem_t wr_data;
    } mem_req_t;

    // sort request from the load/drain control
    typedef struct packed {
        logic start;
        cnt_t count;
    } sort_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/hsa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module hsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/hsa_sorter.sv
// In-place heap sort sequencer working through the element RAM port.
// Depends on hsa_pkg.
`default_nettype none

module hsa_sorter (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hsa_pkg::sort_ctl_t ctl,
    input  wire hsa_pkg::elem_t    rd_data,
    output hsa_pkg::mem_req_t      mem,
    output logic                   done
);

    import hsa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BLOAD,
        S_GETX,
        S_CHK,
        S_LEFT,
        S_RIGHT,
        S_ONE,
        S_PRD0,
        S_PRDK,
        S_PSWAP,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   build_reg, build_next;
    addr_t  k_reg, k_next;
    addr_t  root_reg, root_next;
    addr_t  bottom_reg, bottom_next;
    addr_t  child_reg, child_next;
    addr_t  last_reg, last_next;
    elem_t  x_reg, x_next;
    elem_t  lval_reg, lval_next;

    logic [ADDR_W:0] left_w;
    logic [ADDR_W:0] bottom_w;
    logic            fin;
    addr_t           pick;
    elem_t           pick_val;

    assign left_w   = {root_reg, 1'b0};
    assign bottom_w = {1'b0, bottom_reg};

    always_comb
    begin
        state_next  = state_reg;
        build_next  = build_reg;
        k_next      = k_reg;
        root_next   = root_reg;
        bottom_next = bottom_reg;
        child_next  = child_reg;
        last_next   = last_reg;
        x_next      = x_reg;
        lval_next   = lval_reg;
        mem         = '0;
        done        = 1'b0;
        fin         = 1'b0;
        pick        = child_reg;
        pick_val    = lval_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (ctl.start)
                begin
                    if (ctl.count < CNT_W'(2))
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        last_next  = ADDR_W'(ctl.count - CNT_W'(1));
                        k_next     = ADDR_W'((ctl.count - CNT_W'(1)) >> 1);
                        build_next = 1'b1;
                        state_next = S_BLOAD;
                    end
                end
            end
            S_BLOAD:
            begin
                mem.rd_en   = 1'b1;
                mem.rd_addr = k_reg;
                root_next   = k_reg;
                bottom_next = last_reg;
                state_next  = S_GETX;
            end
            S_GETX:
            begin
                x_next     = rd_data;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (root_reg == '0)
                begin
                    // the top slot has the single child 1
                    if (bottom_reg != '0)
                    begin
                        mem.rd_en   = 1'b1;
                        mem.rd_addr = ADDR_W'(1);
                        child_next  = ADDR_W'(1);
                        state_next  = S_ONE;
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
                else if (left_w > bottom_w)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    mem.rd_en   = 1'b1;
                    mem.rd_addr = left_w[ADDR_W-1:0];
                    child_next  = left_w[ADDR_W-1:0];
                    state_next  = (left_w == bottom_w) ? S_ONE : S_LEFT;
                end
            end
            S_LEFT:
            begin
                lval_next   = rd_data;
                mem.rd_en   = 1'b1;
                mem.rd_addr = child_reg + ADDR_W'(1);
                state_next  = S_RIGHT;
            end
            S_RIGHT:
            begin
                if (lval_reg > rd_data)
                begin
                    pick     = child_reg;
                    pick_val = lval_reg;
                end
                else
                begin
                    pick     = child_reg + ADDR_W'(1);
                    pick_val = rd_data;
                end
                if (pick_val > x_reg)
                begin
                    mem.wr_en   = 1'b1;
                    mem.wr_addr = root_reg;
                    mem.wr_data = pick_val;
                    root_next   = pick;
                    state_next  = S_CHK;
                end
                else
                begin
                    fin = 1'b1;
                end
            end
            S_ONE:
            begin
                if (rd_data > x_reg)
                begin
                    mem.wr_en   = 1'b1;
                    mem.wr_addr = root_reg;
                    mem.wr_data = rd_data;
                    root_next   = child_reg;
                    state_next  = S_CHK;
                end
                else
                begin
                    fin = 1'b1;
                end
            end
            S_PRD0:
            begin
                mem.rd_en   = 1'b1;
                mem.rd_addr = '0;
                state_next  = S_PRDK;
            end
            S_PRDK:
            begin
                lval_next   = rd_data;
                mem.rd_en   = 1'b1;
                mem.rd_addr = k_reg;
                state_next  = S_PSWAP;
            end
            S_PSWAP:
            begin
                // old top goes to the end of the unsorted range
                mem.wr_en   = 1'b1;
                mem.wr_addr = k_reg;
                mem.wr_data = lval_reg;
                x_next      = rd_data;
                root_next   = '0;
                bottom_next = k_reg - ADDR_W'(1);
                state_next  = S_CHK;
            end
            S_FIN:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // sift finished: drop the carried value into the hole
        if (fin)
        begin
            mem.wr_en   = 1'b1;
            mem.wr_addr = root_reg;
            mem.wr_data = x_reg;
            if (build_reg)
            begin
                if (k_reg == '0)
                begin
                    build_next = 1'b0;
                    k_next     = last_reg;
                    state_next = S_PRD0;
                end
                else
                begin
                    k_next     = k_reg - ADDR_W'(1);
                    state_next = S_BLOAD;
                end
            end
            else if (k_reg == ADDR_W'(1))
            begin
                state_next = S_FIN;
            end
            else
            begin
                k_next     = k_reg - ADDR_W'(1);
                state_next = S_PRD0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            build_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            build_reg <= build_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        root_reg   <= root_next;
        bottom_reg <= bottom_next;
        child_reg  <= child_next;
        last_reg   <= last_next;
        x_reg      <= x_next;
        lval_reg   <= lval_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/heap_sort_ascending_unit.sv
// Heap sort unit: loads elements, sorts them in place, drains them ascending.
// Push beat: no result unless the store is full. Pop beat: the RAM read goes through T_POP,
// then the result is registered. A push marked last blocks input for the sort, whose pace
// is set by the single RAM read port.
// Reset (rst_n, async, active low) empties the store; element RAM contents are not cleared.
// Depends on hsa_pkg, hsa_ram, hsa_sorter.
`default_nettype none

module heap_sort_ascending_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // input channel
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               command,
    input  wire logic signed [31:0] value,
    input  wire logic               last,
    // output channel
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      sorted_value,
    output logic                    final_item,
    output logic [1:0]              status
);

    import hsa_pkg::*;

    typedef enum logic [1:0] {
        T_IDLE,   // taking beats
        T_POP,    // RAM read of the next sorted element in flight
        T_START,  // kick the sorter
        T_SORT    // sorter owns the RAM
    } state_t;

    // input word to a stored element (sign extend, then keep WIDTH bits)
    function automatic elem_t to_elem(input logic signed [VAL_W-1:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        return w[WIDTH-1:0];
    endfunction

    // stored element back to the output word
    function automatic logic [VAL_W-1:0] to_word(input elem_t e);
        logic signed [63:0] w;
        w = 64'(e);
        return w[VAL_W-1:0];
    endfunction

    state_t  state_reg, state_next;
    cnt_t    count_reg, count_next;
    cnt_t    rp_reg, rp_next;
    logic    sorted_reg, sorted_next;
    logic    pend_final_reg, pend_final_next;

    logic                    out_valid_reg, out_valid_next;
    logic signed [VAL_W-1:0] out_value_reg, out_value_next;
    logic                    out_final_reg, out_final_next;
    status_t                 out_status_reg, out_status_next;

    mem_req_t  top_req;
    mem_req_t  sort_req;
    mem_req_t  ram_req;
    elem_t     rd_data;
    sort_ctl_t ctl;
    logic      sort_done;
    logic      accept;
    cnt_t      cnt_eff;

    // a beat is taken only when the result slot is free or drains this cycle
    assign in_ready = (state_reg == T_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    assign out_valid    = out_valid_reg;
    assign sorted_value = out_value_reg;
    assign final_item   = out_final_reg;
    assign status       = out_status_reg;

    assign ctl.start = (state_reg == T_START);
    assign ctl.count = count_reg;

    assign ram_req = (state_reg == T_SORT) ? sort_req : top_req;

    hsa_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (rd_data)
    );

    hsa_sorter u_sorter (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .rd_data (rd_data),
        .mem     (sort_req),
        .done    (sort_done)
    );

    // a push after a finished sort starts a fresh load
    assign cnt_eff = sorted_reg ? '0 : count_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rp_next         = rp_reg;
        sorted_next     = sorted_reg;
        pend_final_next = pend_final_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_final_next  = out_final_reg;
        out_status_next = out_status_reg;
        top_req         = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    if (command == CMD_PUSH)
                    begin
                        sorted_next = 1'b0;
                        if (sorted_reg)
                        begin
                            rp_next = '0;
                        end
                        if (cnt_eff >= CNT_W'(DEPTH))
                        begin
                            // store full: drop the value, report it
                            count_next      = cnt_eff;
                            out_valid_next  = 1'b1;
                            out_value_next  = '0;
                            out_final_next  = 1'b0;
                            out_status_next = STATUS_FULL;
                        end
                        else
                        begin
                            top_req.wr_en   = 1'b1;
                            top_req.wr_addr = cnt_eff[ADDR_W-1:0];
                            top_req.wr_data = to_elem(value);
                            count_next      = cnt_eff + CNT_W'(1);
                        end
                        if (last)
                        begin
                            rp_next    = '0;
                            state_next = T_START;
                        end
                    end
                    else if (sorted_reg && (rp_reg < count_reg))
                    begin
                        top_req.rd_en   = 1'b1;
                        top_req.rd_addr = rp_reg[ADDR_W-1:0];
                        pend_final_next = ((rp_reg + CNT_W'(1)) == count_reg);
                        rp_next         = rp_reg + CNT_W'(1);
                        state_next      = T_POP;
                    end
                    else
                    begin
                        // not sorted yet, or drained
                        out_valid_next  = 1'b1;
                        out_value_next  = '0;
                        out_final_next  = 1'b0;
                        out_status_next = STATUS_EMPTY;
                    end
                end
            end
            T_POP:
            begin
                out_valid_next  = 1'b1;
                out_value_next  = to_word(rd_data);
                out_final_next  = pend_final_reg;
                out_status_next = STATUS_OK;
                state_next      = T_IDLE;
            end
            T_START:
            begin
                state_next = T_SORT;
            end
            T_SORT:
            begin
                if (sort_done)
                begin
                    sorted_next = 1'b1;
                    rp_next     = '0;
                    state_next  = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            count_reg     <= '0;
            rp_reg        <= '0;
            sorted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rp_reg        <= rp_next;
            sorted_reg    <= sorted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_final_reg <= pend_final_next;
        out_value_reg  <= out_value_next;
        out_final_reg  <= out_final_next;
        out_status_reg <= out_status_next;
    end

endmodule

`default_nettype wire
